FILE: hdl/rhc_pkg.sv
`default_nettype none

package rhc_pkg;

    localparam int CH_W   = 8;
    localparam int HUE_W  = 9;
    localparam int PCT_W  = 7;
    localparam int DVD_W  = 17;
    localparam int NUM_CH = 3;

    localparam logic [HUE_W-1:0] HUE_MAX  = 9'd360;
    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;
    localparam logic [CH_W-1:0]  CH_MAX   = 8'd255;
    localparam logic [CH_W-1:0]  PCT_DIV  = 8'd100;
    localparam logic [CH_W-1:0]  VAL_DIV  = 8'd255;
    localparam logic [DVD_W-1:0] HUE_STEP = 17'd60;
    localparam logic [DVD_W-1:0] PCT_MUL  = 17'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV1,
        ST_MID,
        ST_DIV2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pure_t;

    // k * 255 / 60 is exactly k * 17 / 4
    function automatic logic [CH_W-1:0] scale60(input logic [6:0] k);
        logic [10:0] t;
        t = {k, 4'b0000} + 11'(k);
        return t[9:2];
    endfunction

    function automatic pure_t pure_color(input logic [HUE_W-1:0] h);
        pure_t p;
        if (h <= 9'd60 || h >= 9'd300) begin
            p.red = CH_MAX;
        end else if (h <= 9'd120) begin
            p.red = scale60(7'(9'd120 - h));
        end else if (h <= 9'd240) begin
            p.red = '0;
        end else begin
            p.red = scale60(7'(h - 9'd240));
        end
        if (h <= 9'd60) begin
            p.blue = scale60(7'(h));
        end else if (h <= 9'd180) begin
            p.blue = CH_MAX;
        end else if (h <= 9'd240) begin
            p.blue = scale60(7'(9'd240 - h));
        end else begin
            p.blue = '0;
        end
        if (h <= 9'd120) begin
            p.green = '0;
        end else if (h <= 9'd180) begin
            p.green = scale60(7'(h - 9'd120));
        end else if (h <= 9'd300) begin
            p.green = CH_MAX;
        end else begin
            p.green = scale60(7'(HUE_MAX - h));
        end
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rgb_hsv_color_converter_top.sv
// RGB <-> HSV color converter. Each input beat carries an operation bit: 0 converts
// s_red_in/s_green_in/s_blue_in to hue (0..360 degrees), saturation and value
// (0..100 percent), 1 converts s_hue_in/s_sat_in/s_val_in (clamped to 360/100/100)
// to 8-bit RGB. Every result beat also carries the fully saturated, fully bright
// color of the hue (m_pure_*) and passes through the side it did not compute. All
// quotients are truncated toward zero. A gray input (all channels equal) keeps the
// hue of the previous beat; that hue is zero after reset. The work runs on three
// bit-serial restoring dividers working side by side, one quotient bit per cycle
// for a 17-bit dividend. RGB to HSV needs one pass of the dividers; HSV to RGB
// needs two dependent passes (blend toward white, then scale by value). One beat
// is in work at a time. The finished result sits in an output register, so a new
// input beat is accepted while the previous result still waits for m_ready.
`default_nettype none

module rgb_hsv_color_converter_top (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_operation,
    input  wire logic [rhc_pkg::CH_W-1:0]  s_red_in,
    input  wire logic [rhc_pkg::CH_W-1:0]  s_green_in,
    input  wire logic [rhc_pkg::CH_W-1:0]  s_blue_in,
    input  wire logic [rhc_pkg::HUE_W-1:0] s_hue_in,
    input  wire logic [rhc_pkg::PCT_W-1:0] s_sat_in,
    input  wire logic [rhc_pkg::PCT_W-1:0] s_val_in,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic      [rhc_pkg::HUE_W-1:0] m_hue_out,
    output logic      [rhc_pkg::PCT_W-1:0] m_sat_out,
    output logic      [rhc_pkg::PCT_W-1:0] m_val_out,
    output logic      [rhc_pkg::CH_W-1:0]  m_red_out,
    output logic      [rhc_pkg::CH_W-1:0]  m_green_out,
    output logic      [rhc_pkg::CH_W-1:0]  m_blue_out,
    output logic      [rhc_pkg::CH_W-1:0]  m_pure_red,
    output logic      [rhc_pkg::CH_W-1:0]  m_pure_green,
    output logic      [rhc_pkg::CH_W-1:0]  m_pure_blue
);

    import rhc_pkg::*;

    // control
    state_t state_reg, state_next;
    logic   m_valid_reg;
    logic   accept;
    logic   out_free;
    logic   div_start;
    logic   div_done;

    // kept hue for gray inputs
    logic [HUE_W-1:0] last_hue_reg;

    // item registers
    logic             op_reg;
    logic [CH_W-1:0]  ch_reg [NUM_CH];
    logic [HUE_W-1:0] hue_reg;
    logic [PCT_W-1:0] sat_reg;
    logic [PCT_W-1:0] val_reg;
    logic             neg_reg;
    logic             gray_reg;
    logic             mxz_reg;

    // rgb to hsv operand logic
    logic [CH_W-1:0]  mx, mn, dif;
    logic             red_big, green_big;
    logic [10:0]      num_mag;
    logic             hue_neg;
    logic [HUE_W-1:0] hue_calc;
    logic [HUE_W-1:0] q_hue;

    // pure-hue color of the hue in use
    pure_t            pure_rgb;
    logic [CH_W-1:0]  pure_ch [NUM_CH];

    // divider lanes
    logic [DVD_W-1:0] dvd [NUM_CH];
    logic [CH_W-1:0]  dsr [NUM_CH];
    logic [DVD_W-1:0] quo [NUM_CH];
    logic [NUM_CH-1:0] div_busy;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // channel extremes and the hue numerator magnitude
    always_comb begin
        mx = ch_reg[0];
        if (ch_reg[1] > mx) begin
            mx = ch_reg[1];
        end
        if (ch_reg[2] > mx) begin
            mx = ch_reg[2];
        end
        mn = ch_reg[0];
        if (ch_reg[1] < mn) begin
            mn = ch_reg[1];
        end
        if (ch_reg[2] < mn) begin
            mn = ch_reg[2];
        end
        dif       = mx - mn;
        red_big   = (ch_reg[0] >= ch_reg[1]) && (ch_reg[0] >= ch_reg[2]);
        green_big = (ch_reg[1] >= ch_reg[0]) && (ch_reg[1] >= ch_reg[2]);
        if (red_big) begin
            // hue = -60*(g-b)/d: positive when blue exceeds green
            hue_neg = (ch_reg[1] > ch_reg[2]);
            if (ch_reg[1] >= ch_reg[2]) begin
                num_mag = 11'(ch_reg[1] - ch_reg[2]);
            end else begin
                num_mag = 11'(ch_reg[2] - ch_reg[1]);
            end
        end else if (green_big) begin
            hue_neg = 1'b1;
            num_mag = {2'b00, dif, 1'b0} + 11'(ch_reg[2]) - 11'(ch_reg[0]);
        end else begin
            hue_neg = 1'b1;
            num_mag = {1'b0, dif, 2'b00} + 11'(ch_reg[0]) - 11'(ch_reg[1]);
        end
    end

    // negative hue wraps by adding a full turn
    always_comb begin
        q_hue = quo[0][HUE_W-1:0];
        if (gray_reg) begin
            hue_calc = last_hue_reg;
        end else if (neg_reg && q_hue != '0) begin
            hue_calc = HUE_MAX - q_hue;
        end else begin
            hue_calc = q_hue;
        end
    end

    assign pure_rgb   = pure_color(hue_reg);
    assign pure_ch[0] = pure_rgb.red;
    assign pure_ch[1] = pure_rgb.green;
    assign pure_ch[2] = pure_rgb.blue;

    // operand selection for the divider lanes
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            dvd[i] = '0;
            dsr[i] = PCT_DIV;
        end
        if (!op_reg) begin
            dvd[0] = DVD_W'(num_mag) * HUE_STEP;
            dsr[0] = dif;
            dvd[1] = DVD_W'(dif) * PCT_MUL;
            dsr[1] = mx;
            dvd[2] = DVD_W'(mx) * PCT_MUL;
            dsr[2] = VAL_DIV;
        end else if (state_reg == ST_LOAD) begin
            // blend toward white by saturation
            for (int i = 0; i < NUM_CH; i++) begin
                dvd[i] = DVD_W'(CH_MAX - pure_ch[i]) * DVD_W'(PCT_MAX - sat_reg);
            end
        end else begin
            // scale by value
            for (int i = 0; i < NUM_CH; i++) begin
                dvd[i] = DVD_W'(ch_reg[i]) * DVD_W'(val_reg);
            end
        end
    end

    assign div_start = (state_reg == ST_LOAD) || (state_reg == ST_MID);
    assign div_done  = !div_busy[0];

    for (genvar gi = 0; gi < NUM_CH; gi++) begin : g_div
        rhc_serial_div #(
            .DVD_W (DVD_W),
            .DSR_W (CH_W)
        ) u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (div_start),
            .dividend (dvd[gi]),
            .divisor  (dsr[gi]),
            .busy     (div_busy[gi]),
            .quotient (quo[gi])
        );
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_DIV1;
            end
            ST_DIV1: begin
                if (div_done) begin
                    state_next = op_reg ? ST_MID : ST_DONE;
                end
            end
            ST_MID: begin
                state_next = ST_DIV2;
            end
            ST_DIV2: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            last_hue_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg  <= 1'b1;
                last_hue_reg <= hue_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_operation;
            ch_reg[0] <= s_red_in;
            ch_reg[1] <= s_green_in;
            ch_reg[2] <= s_blue_in;
            hue_reg   <= (s_hue_in > HUE_MAX) ? HUE_MAX : s_hue_in;
            sat_reg   <= (s_sat_in > PCT_MAX) ? PCT_MAX : s_sat_in;
            val_reg   <= (s_val_in > PCT_MAX) ? PCT_MAX : s_val_in;
        end
        if (state_reg == ST_LOAD) begin
            neg_reg  <= hue_neg;
            gray_reg <= (dif == '0);
            mxz_reg  <= (mx == '0);
        end
        if (state_reg == ST_DIV1 && div_done) begin
            if (!op_reg) begin
                hue_reg <= hue_calc;
                sat_reg <= mxz_reg ? '0 : quo[1][PCT_W-1:0];
                val_reg <= quo[2][PCT_W-1:0];
            end else begin
                for (int i = 0; i < NUM_CH; i++) begin
                    ch_reg[i] <= pure_ch[i] + quo[i][CH_W-1:0];
                end
            end
        end
        if (state_reg == ST_DIV2 && div_done) begin
            for (int i = 0; i < NUM_CH; i++) begin
                ch_reg[i] <= quo[i][CH_W-1:0];
            end
        end
        if (state_reg == ST_DONE && out_free) begin
            m_hue_out    <= hue_reg;
            m_sat_out    <= sat_reg;
            m_val_out    <= val_reg;
            m_red_out    <= ch_reg[0];
            m_green_out  <= ch_reg[1];
            m_blue_out   <= ch_reg[2];
            m_pure_red   <= pure_rgb.red;
            m_pure_green <= pure_rgb.green;
            m_pure_blue  <= pure_rgb.blue;
        end
    end

    // hue never leaves its range when the result is formed
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> hue_reg <= HUE_MAX)
        else $error("hue out of range at result");

    // kept hue stays in range for gray inputs
    a_last_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        last_hue_reg <= HUE_MAX)
        else $error("kept hue out of range");

    // all divider lanes start together
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> div_busy[0] && div_busy[1] && div_busy[2])
        else $error("divider lanes did not start");

    // an accepted beat goes straight to operand load
    a_accept_load: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_LOAD)
        else $error("accepted beat not loaded");

endmodule

`default_nettype wire

FILE: hdl/rhc_serial_div.sv
`default_nettype none

module rhc_serial_div #(
    parameter int DVD_W = 17,
    parameter int DSR_W = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DSR_W-1:0] divisor,
    output logic                  busy,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W:0]   trial;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial      = {rem_reg, quo_reg[DVD_W-1]};
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        if (start) begin
            count_next = CNT_W'(DVD_W);
            quo_next   = dividend;
            rem_next   = '0;
        end else if (count_reg != '0) begin
            count_next = count_reg - 1'b1;
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = DSR_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DSR_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign busy     = (count_reg != '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: sim/rgb_hsv_color_converter_top_test.sv
`default_nettype none

module rgb_hsv_color_converter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rhc_pkg::*;

    // operation codes carried by s_operation
    localparam logic OP_RGB2HSV = 1'b0;
    localparam logic OP_HSV2RGB = 1'b1;

    localparam int N_DIR      = 24;
    localparam int N_RAND     = 430;
    localparam int N_QUIET    = 80;     // last random beats run without idling
    localparam int DRAIN_AT   = 200;    // random beat index where the sender waits for all results
    localparam int TAIL_WAIT  = 64;     // more than one hsv to rgb pass of the block
    localparam int MAX_REPORT = 10;

    // one input beat
    typedef struct packed {
        logic             op;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] val;
    } color_beat_t;

    // one result beat, in port order
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] val;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  pure_red;
        logic [CH_W-1:0]  pure_green;
        logic [CH_W-1:0]  pure_blue;
    } color_res_t;

    // directed table row: the beat, and a typed-in result where one is known
    typedef struct packed {
        color_beat_t beat;
        logic        known;
        color_res_t  want;
    } dir_row_t;

    // clock, reset and block inputs, all known from time zero
    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_operation = 1'b0;
    logic [CH_W-1:0]     s_red_in    = '0;
    logic [CH_W-1:0]     s_green_in  = '0;
    logic [CH_W-1:0]     s_blue_in   = '0;
    logic [HUE_W-1:0]    s_hue_in    = '0;
    logic [PCT_W-1:0]    s_sat_in    = '0;
    logic [PCT_W-1:0]    s_val_in    = '0;
    logic                m_ready     = 1'b0;

    logic                s_ready;
    logic                m_valid;
    logic [HUE_W-1:0]    m_hue_out;
    logic [PCT_W-1:0]    m_sat_out;
    logic [PCT_W-1:0]    m_val_out;
    logic [CH_W-1:0]     m_red_out;
    logic [CH_W-1:0]     m_green_out;
    logic [CH_W-1:0]     m_blue_out;
    logic [CH_W-1:0]     m_pure_red;
    logic [CH_W-1:0]     m_pure_green;
    logic [CH_W-1:0]     m_pure_blue;

    // predictor state: hue of the most recent beat, kept for gray inputs
    logic [HUE_W-1:0]    kept_hue = '0;
    color_res_t          pending_colors [$];
    int                  bad_count = 0;
    logic                idle_en = 1'b1;

    rgb_hsv_color_converter_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .s_hue_in    (s_hue_in),
        .s_sat_in    (s_sat_in),
        .s_val_in    (s_val_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hue_out   (m_hue_out),
        .m_sat_out   (m_sat_out),
        .m_val_out   (m_val_out),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_pure_red  (m_pure_red),
        .m_pure_green(m_pure_green),
        .m_pure_blue (m_pure_blue)
    );

    always #2 aclk = ~aclk;

    // pure-hue color, each ramp is k*255/60 truncated
    function automatic void hue_to_pure(input int h, output int pr, output int pg,
                                        output int pb);
        if (h <= 60 || h >= 300) begin
            pr = 255;
        end else if (h <= 120) begin
            pr = ((120 - h) * 255) / 60;
        end else if (h <= 240) begin
            pr = 0;
        end else begin
            pr = ((h - 240) * 255) / 60;
        end
        if (h <= 60) begin
            pb = (h * 255) / 60;
        end else if (h <= 180) begin
            pb = 255;
        end else if (h <= 240) begin
            pb = ((240 - h) * 255) / 60;
        end else begin
            pb = 0;
        end
        if (h <= 120) begin
            pg = 0;
        end else if (h <= 180) begin
            pg = ((h - 120) * 255) / 60;
        end else if (h <= 300) begin
            pg = 255;
        end else begin
            pg = ((360 - h) * 255) / 60;
        end
    endfunction

    // blend toward white by saturation, then scale by value
    function automatic int blend_channel(input int p, input int s, input int v);
        int c;
        c = p + ((255 - p) * (100 - s)) / 100;
        return (c * v) / 100;
    endfunction

    // expected result of one beat; advances kept_hue
    function automatic color_res_t convert_color(input color_beat_t b);
        int r, g, bl, mx, mn, d, h, s, v, pr, pg, pb;
        color_res_t o;
        if (b.op == OP_RGB2HSV) begin
            r  = b.red;
            g  = b.green;
            bl = b.blue;
            mx = r;
            if (g > mx) mx = g;
            if (bl > mx) mx = bl;
            mn = r;
            if (g < mn) mn = g;
            if (bl < mn) mn = bl;
            d = mx - mn;
            v = (mx * 100) / 255;
            s = (mx != 0) ? (d * 100) / mx : 0;
            if (d != 0) begin
                // reversed sign on every sector, int division truncates toward zero
                if (r >= g && r >= bl) begin
                    h = (-60 * (g - bl)) / d;
                end else if (g >= r && g >= bl) begin
                    h = (-60 * (2 * d + bl - r)) / d;
                end else begin
                    h = (-60 * (4 * d + r - g)) / d;
                end
            end else begin
                // gray keeps the previous hue
                h = int'(kept_hue);
            end
            if (h < 0) h = h % 360 + 360;
            if (h > 360) h = h % 360;
            hue_to_pure(h, pr, pg, pb);
        end else begin
            // out-of-range hsv is clamped before use
            h = (b.hue > HUE_MAX) ? 360 : int'(b.hue);
            s = (b.sat > PCT_MAX) ? 100 : int'(b.sat);
            v = (b.val > PCT_MAX) ? 100 : int'(b.val);
            hue_to_pure(h, pr, pg, pb);
            r  = blend_channel(pr, s, v);
            g  = blend_channel(pg, s, v);
            bl = blend_channel(pb, s, v);
        end
        kept_hue = h[HUE_W-1:0];
        o.hue        = h[HUE_W-1:0];
        o.sat        = s[PCT_W-1:0];
        o.val        = v[PCT_W-1:0];
        o.red        = r[CH_W-1:0];
        o.green      = g[CH_W-1:0];
        o.blue       = bl[CH_W-1:0];
        o.pure_red   = pr[CH_W-1:0];
        o.pure_green = pg[CH_W-1:0];
        o.pure_blue  = pb[CH_W-1:0];
        return o;
    endfunction

    function automatic color_res_t mk_res(input int h, input int s, input int v,
                                          input int r, input int g, input int b,
                                          input int pr, input int pg, input int pb);
        color_res_t o;
        o = {HUE_W'(h), PCT_W'(s), PCT_W'(v), CH_W'(r), CH_W'(g), CH_W'(b),
             CH_W'(pr), CH_W'(pg), CH_W'(pb)};
        return o;
    endfunction

    // directed row: a/b/c are rgb for rgb to hsv, hue/sat/val for hsv to rgb;
    // the unused side gets random bits
    function automatic dir_row_t mk_row(input logic op, input int a, input int b,
                                        input int c, input logic known,
                                        input color_res_t want);
        dir_row_t row;
        row.beat.op    = op;
        row.beat.red   = CH_W'($urandom);
        row.beat.green = CH_W'($urandom);
        row.beat.blue  = CH_W'($urandom);
        row.beat.hue   = HUE_W'($urandom);
        row.beat.sat   = PCT_W'($urandom);
        row.beat.val   = PCT_W'($urandom);
        if (op == OP_RGB2HSV) begin
            row.beat.red   = CH_W'(a);
            row.beat.green = CH_W'(b);
            row.beat.blue  = CH_W'(c);
        end else begin
            row.beat.hue = HUE_W'(a);
            row.beat.sat = PCT_W'(b);
            row.beat.val = PCT_W'(c);
        end
        row.known = known;
        row.want  = want;
        return row;
    endfunction

    // random beat, shaped toward gray, sector edges and clamping
    function automatic color_beat_t rand_beat();
        color_beat_t b;
        int edge_hue [8];
        edge_hue = '{0, 60, 120, 180, 240, 300, 359, 360};
        b.op    = 1'($urandom);
        b.red   = CH_W'($urandom);
        b.green = CH_W'($urandom);
        b.blue  = CH_W'($urandom);
        b.hue   = HUE_W'($urandom);
        b.sat   = PCT_W'($urandom);
        b.val   = PCT_W'($urandom);
        if (b.op == OP_RGB2HSV) begin
            case ($urandom_range(0, 7))
                0: begin
                    b.green = b.red;
                    b.blue  = b.red;
                end
                1: b.blue = b.green;
                2: begin
                    b.red   = $urandom_range(0, 1) ? CH_MAX : '0;
                    b.green = $urandom_range(0, 1) ? CH_MAX : '0;
                    b.blue  = $urandom_range(0, 1) ? CH_MAX : '0;
                end
                3: begin
                    b.green = b.red + CH_W'($urandom_range(0, 2));
                    b.blue  = b.red - CH_W'($urandom_range(0, 2));
                end
                default: ;
            endcase
        end else begin
            case ($urandom_range(0, 5))
                0: b.hue = HUE_W'(edge_hue[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1);
                1: b.hue = HUE_W'($urandom_range(361, 511));
                2, 3: b.hue = HUE_W'($urandom_range(0, 360));
                default: ;
            endcase
            if ($urandom_range(0, 3) != 0) b.sat = PCT_W'($urandom_range(0, 100));
            if ($urandom_range(0, 3) != 0) b.val = PCT_W'($urandom_range(0, 100));
        end
        return b;
    endfunction

    // present one beat from a falling edge, hold it until accepted, then log
    // the expected result; returns at the falling edge after acceptance
    task automatic drive_beat(input color_beat_t b, input logic known,
                              input color_res_t want);
        int gap;
        color_res_t pred;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= b.op;
        s_red_in    <= b.red;
        s_green_in  <= b.green;
        s_blue_in   <= b.blue;
        s_hue_in    <= b.hue;
        s_sat_in    <= b.sat;
        s_val_in    <= b.val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // predictor runs in acceptance order so kept_hue follows the block
        pred = convert_color(b);
        pending_colors.push_back(known ? want : pred);
        @(negedge aclk);
    endtask

    // sink side: m_ready drops in bursts of random length while idling is on
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (idle_en && stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 18) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result checker: every accepted result beat against the oldest expectation
    always @(posedge aclk) begin
        color_res_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_hue_out, m_sat_out, m_val_out, m_red_out, m_green_out, m_blue_out,
                   m_pure_red, m_pure_green, m_pure_blue};
            if (pending_colors.size() == 0) begin
                bad_count++;
                if (bad_count <= MAX_REPORT)
                    $display("%0t: result beat with nothing expected, hsv %0d/%0d/%0d",
                             $realtime, got.hue, got.sat, got.val);
            end else begin
                want = pending_colors.pop_front();
                if (got.hue !== want.hue || got.sat !== want.sat || got.val !== want.val ||
                    got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.pure_red !== want.pure_red ||
                    got.pure_green !== want.pure_green ||
                    got.pure_blue !== want.pure_blue) begin
                    bad_count++;
                    if (bad_count <= MAX_REPORT) begin
                        $display("%0t: mismatch exp hsv %0d/%0d/%0d rgb %0d/%0d/%0d pure %0d/%0d/%0d",
                                 $realtime, want.hue, want.sat, want.val, want.red,
                                 want.green, want.blue, want.pure_red, want.pure_green,
                                 want.pure_blue);
                        $display("%0t:          got hsv %0d/%0d/%0d rgb %0d/%0d/%0d pure %0d/%0d/%0d",
                                 $realtime, got.hue, got.sat, got.val, got.red,
                                 got.green, got.blue, got.pure_red, got.pure_green,
                                 got.pure_blue);
                    end
                end
            end
        end
    end

    // main sequence
    initial begin
        dir_row_t dir_tab [N_DIR];
        color_res_t none;
        none = '0;
        // gray rows right after reset rely on the kept hue being zero
        dir_tab = '{
            // black after reset: kept hue zero
            mk_row(OP_RGB2HSV, 0, 0, 0, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 255, 0, 0)),
            // full red
            mk_row(OP_RGB2HSV, 255, 0, 0, 1'b1, mk_res(0, 100, 100, 255, 0, 0, 255, 0, 0)),
            // white, still gray on hue zero
            mk_row(OP_RGB2HSV, 255, 255, 255, 1'b1,
                   mk_res(0, 0, 100, 255, 255, 255, 255, 0, 0)),
            mk_row(OP_RGB2HSV, 0, 255, 0, 1'b0, none),
            // gray after green keeps that hue
            mk_row(OP_RGB2HSV, 128, 128, 128, 1'b0, none),
            mk_row(OP_RGB2HSV, 0, 0, 255, 1'b0, none),
            mk_row(OP_RGB2HSV, 255, 255, 0, 1'b0, none),
            mk_row(OP_RGB2HSV, 0, 255, 255, 1'b0, none),
            mk_row(OP_RGB2HSV, 255, 0, 255, 1'b0, none),
            // negative hue wraps, tiny positive quotient truncates to zero
            mk_row(OP_RGB2HSV, 255, 254, 253, 1'b0, none),
            mk_row(OP_RGB2HSV, 255, 0, 1, 1'b0, none),
            mk_row(OP_RGB2HSV, 1, 0, 0, 1'b0, none),
            mk_row(OP_HSV2RGB, 0, 100, 100, 1'b1, mk_res(0, 100, 100, 255, 0, 0, 255, 0, 0)),
            mk_row(OP_HSV2RGB, 0, 0, 100, 1'b1,
                   mk_res(0, 0, 100, 255, 255, 255, 255, 0, 0)),
            mk_row(OP_HSV2RGB, 0, 100, 0, 1'b1, mk_res(0, 100, 0, 0, 0, 0, 255, 0, 0)),
            // everything above range clamps to 360/100/100
            mk_row(OP_HSV2RGB, 511, 127, 127, 1'b1,
                   mk_res(360, 100, 100, 255, 0, 0, 255, 0, 0)),
            // gray after the clamped hue of 360
            mk_row(OP_RGB2HSV, 7, 7, 7, 1'b0, none),
            mk_row(OP_HSV2RGB, 361, 101, 101, 1'b0, none),
            mk_row(OP_HSV2RGB, 60, 50, 50, 1'b0, none),
            mk_row(OP_HSV2RGB, 120, 33, 77, 1'b0, none),
            mk_row(OP_HSV2RGB, 180, 1, 99, 1'b0, none),
            mk_row(OP_HSV2RGB, 240, 99, 1, 1'b0, none),
            mk_row(OP_HSV2RGB, 300, 75, 100, 1'b0, none),
            mk_row(OP_HSV2RGB, 359, 100, 100, 1'b0, none)
        };

        // synchronous reset, released at a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tab[i])
            drive_beat(dir_tab[i].beat, dir_tab[i].known, dir_tab[i].want);

        for (int i = 0; i < N_RAND; i++) begin
            if (i == DRAIN_AT) begin
                // sender holds off until every result is back
                s_valid <= 1'b0;
                while (pending_colors.size() != 0) @(negedge aclk);
                @(negedge aclk);
            end
            if (i == N_RAND - N_QUIET) idle_en = 1'b0;
            drive_beat(rand_beat(), 1'b0, none);
        end
        s_valid <= 1'b0;

        while (pending_colors.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);

        if (bad_count == 0 && pending_colors.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, far above the slowest correct run
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
